// ===== hw/rtl/dbs_pkg.sv =====
package dbs_pkg;

  // Table geometry and number formats
  localparam int TABLE_DEPTH      = 4096;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int RANDOM_BITS      = 16;

  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WEIGHT_W   = WEIGHT_FRAC_BITS + 1;
  localparam int SUM_W      = 30;
  localparam int HIST_W     = 16;
  localparam int HIST_DEPTH = TABLE_DEPTH + 1;
  localparam int PROD_W     = RANDOM_BITS + SUM_W;
  localparam int CMD_W      = 2;
  localparam int COUNT_W    = 8;

  // Partial sum over the whole table never overflows this width
  localparam int PART_RAW_W = IDX_W + WEIGHT_FRAC_BITS + 1;
  localparam int PART_W     = (PART_RAW_W > SUM_W) ? PART_RAW_W : SUM_W;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = {1'b1, {WEIGHT_FRAC_BITS{1'b0}}};
  localparam logic [CNT_W-1:0]    DEPTH_CNT  = CNT_W'(TABLE_DEPTH);
  localparam logic [HIST_W-1:0]   HIST_MAX   = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_DRAW = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_SUM     = 9'b000000100,
    ST_MUL     = 9'b000001000,
    ST_SCAN    = 9'b000010000,
    ST_HIST_RD = 9'b000100000,
    ST_HIST_WR = 9'b001000000,
    ST_FINISH  = 9'b010000000,
    ST_SPARE   = 9'b100000000
  } state_t;

endpackage

// ===== hw/rtl/decayed_boundary_selector.sv =====
// Sequence: a load or unused command goes straight to finish; an add walks the newly covered
//   entries; a draw scales the fraction, walks the offsets up to a hit or the end, then
//   updates the histogram; both walks are paced by the one-entry-per-cycle weight read port.
// Throughput: one word in flight; the next word is taken while the last result waits.
// Reset: synchronous; after reset the histogram memory is cleared, all TABLE_DEPTH + 1
//   entries, during which no word is accepted.
module decayed_boundary_selector
  import dbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [IDX_W-1:0]      entry_index,
  input  logic [WEIGHT_W-1:0]   weight_value,
  input  logic [COUNT_W-1:0]    boundary_count,
  input  logic [RANDOM_BITS-1:0] random_fraction,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [CNT_W-1:0]      picked_boundary,
  output logic                  bin_found,
  output logic                  status
);

  state_t state;

  logic [CNT_W-1:0]       boundary_total;
  logic [SUM_W-1:0]       weight_sum;
  logic [RANDOM_BITS-1:0] rnd_q;
  logic [SUM_W-1:0]       target;
  logic [PART_W-1:0]      partial;
  logic [CNT_W-1:0]       walk_idx;
  logic [CNT_W-1:0]       walk_stop;
  logic [CNT_W-1:0]       data_idx;
  logic                   data_valid;
  logic [CNT_W-1:0]       pick_q;
  logic                   res_found;
  logic                   res_status;
  logic [CNT_W-1:0]       clr_idx;

  logic [WEIGHT_W-1:0] weight_mem [TABLE_DEPTH];
  logic [HIST_W-1:0]   hist_mem [HIST_DEPTH];
  logic [WEIGHT_W-1:0] wt_rdata;
  logic [HIST_W-1:0]   hist_rdata;

  logic                accept;
  logic                walking;
  logic                issue;
  logic                wt_we;
  logic [WEIGHT_W-1:0] wt_wdata;
  logic                hist_we;
  logic [CNT_W-1:0]    hist_waddr;
  logic [HIST_W-1:0]   hist_wdata;
  logic [SUM_W:0]      sum_plus;
  logic [PART_W:0]     bin_end;
  logic [PROD_W-1:0]   product;
  logic [CNT_W:0]      add_end;
  logic                result_free;

  // Handshake and walk control
  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && !item_stall;
  assign walking     = (state == ST_SUM) || (state == ST_SCAN);
  assign issue       = walking && (walk_idx < walk_stop);
  assign result_free = !result_valid || !result_stall;

  // Saturate the loaded weight at one
  assign wt_wdata = (weight_value > WEIGHT_ONE) ? WEIGHT_ONE : weight_value;
  assign wt_we    = accept && (command == CMD_LOAD) && (CNT_W'(entry_index) < DEPTH_CNT);

  // Datapath arithmetic
  assign sum_plus = (SUM_W + 1)'(weight_sum) + (SUM_W + 1)'(wt_rdata);
  assign bin_end  = (PART_W + 1)'(partial) + (PART_W + 1)'(wt_rdata);
  assign product  = PROD_W'(rnd_q) * PROD_W'(weight_sum);
  assign add_end  = (CNT_W + 1)'(boundary_total) + (CNT_W + 1)'(boundary_count);

  // Histogram write port: clearing pass or saturating increment
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = pick_q;
    hist_wdata = (hist_rdata == HIST_MAX) ? HIST_MAX : hist_rdata + HIST_W'(1);
    case (state)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_idx;
        hist_wdata = '0;
      end
      ST_HIST_WR: begin
        hist_we = 1'b1;
      end
      default: begin
        hist_we = 1'b0;
      end
    endcase
  end

  // Weight memory
  always_ff @(posedge clk) begin
    if (wt_we) begin
      weight_mem[entry_index] <= wt_wdata;
    end
    if (issue) begin
      wt_rdata <= weight_mem[walk_idx[IDX_W-1:0]];
    end
  end

  // Histogram memory
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (state == ST_HIST_RD) begin
      hist_rdata <= hist_mem[pick_q];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      boundary_total <= '0;
      weight_sum     <= '0;
      result_valid   <= 1'b0;
      data_valid     <= 1'b0;
    end else begin
      // Drop the result word once taken, unless a new one is loaded now
      if (result_valid && !result_stall && (state != ST_FINISH)) begin
        result_valid <= 1'b0;
      end

      // Advance the read pipeline
      data_valid <= issue;
      if (issue) begin
        data_idx <= walk_idx;
        walk_idx <= walk_idx + CNT_W'(1);
      end

      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + CNT_W'(1);
          if (clr_idx == DEPTH_CNT) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (accept) begin
            pick_q     <= '0;
            res_found  <= 1'b0;
            res_status <= 1'b0;
            partial    <= '0;
            rnd_q      <= random_fraction;
            case (command)
              CMD_ADD: begin
                walk_idx <= boundary_total;
                if (add_end > (CNT_W + 1)'(TABLE_DEPTH)) begin
                  walk_stop      <= DEPTH_CNT;
                  boundary_total <= DEPTH_CNT;
                  res_status     <= 1'b1;
                end else begin
                  walk_stop      <= add_end[CNT_W-1:0];
                  boundary_total <= add_end[CNT_W-1:0];
                end
                state <= ST_SUM;
              end
              CMD_DRAW: begin
                walk_idx  <= '0;
                walk_stop <= boundary_total;
                state     <= ST_MUL;
              end
              default: begin
                state <= ST_FINISH;
              end
            endcase
          end
        end

        // Accumulate newly covered weights, saturating the sum
        ST_SUM: begin
          if (data_valid) begin
            weight_sum <= sum_plus[SUM_W] ? '1 : sum_plus[SUM_W-1:0];
          end else if (!issue) begin
            state <= ST_FINISH;
          end
        end

        // Scale the random fraction by the running sum
        ST_MUL: begin
          target <= product[RANDOM_BITS +: SUM_W];
          state  <= ST_SCAN;
        end

        // Walk the bins; partial never passes target before a hit
        ST_SCAN: begin
          if (data_valid) begin
            if ((PART_W + 1)'(target) < bin_end) begin
              res_found <= 1'b1;
              pick_q    <= boundary_total - data_idx;
              state     <= ST_HIST_RD;
            end else begin
              partial <= bin_end[PART_W-1:0];
            end
          end else if (!issue) begin
            state <= ST_HIST_RD;
          end
        end

        ST_HIST_RD: begin
          state <= ST_HIST_WR;
        end

        ST_HIST_WR: begin
          state <= ST_FINISH;
        end

        // Hold until the output register is free
        ST_FINISH: begin
          if (result_free) begin
            result_valid    <= 1'b1;
            picked_boundary <= pick_q;
            bin_found       <= res_found;
            status          <= res_status;
            state           <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    boundary_total <= DEPTH_CNT)
    else $error("boundary total above table depth");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_FINISH))
    else $error("result word loaded outside finish");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    walking |-> walk_idx <= walk_stop)
    else $error("walk index passed its stop");

  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HIST_RD && res_found) |-> (pick_q != '0 && pick_q <= boundary_total))
    else $error("found pick outside boundary range");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import dbs_pkg::*;
();

  localparam int RUN_LIMIT   = 2_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_WORDS = 110;
  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;

  typedef struct packed {
    logic [CNT_W-1:0] pick;
    logic             found;
    logic             status;
  } pick_result_t;

  // Selector state mirror plus the queue of results still owed by the block.
  // The draw histogram never reaches a port, so it is not tracked.
  class selection_scoreboard;
    logic [WEIGHT_W-1:0] weights [TABLE_DEPTH];
    int unsigned         total;
    longint unsigned     wsum;
    pick_result_t        expected_picks [$];
    int                  errors;
    int                  seen;

    function new();
      foreach (weights[i]) weights[i] = '0;
      total  = 0;
      wsum   = 0;
      errors = 0;
      seen   = 0;
    endfunction

    function int pending();
      return expected_picks.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH %0d: %s", errors, msg);
    endtask

    // Apply one accepted word and queue the result it owes
    function void note_word(input cmd_t c, input logic [IDX_W-1:0] idx,
                            input logic [WEIGHT_W-1:0] w,
                            input logic [COUNT_W-1:0] cnt,
                            input logic [RANDOM_BITS-1:0] r);
      pick_result_t    e;
      int unsigned     stop;
      int unsigned     i;
      longint unsigned target;
      longint unsigned partial;
      e = '0;
      case (c)
        CMD_LOAD: begin
          // clamp weights above one
          weights[idx] = (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
        end
        CMD_ADD: begin
          stop = total + cnt;
          if (stop > TABLE_DEPTH) begin
            stop     = TABLE_DEPTH;
            e.status = 1'b1;
          end
          for (i = total; i < stop; i++) begin
            wsum += weights[i];
            if (wsum > SUM_LIMIT) wsum = SUM_LIMIT;
          end
          total = stop;
        end
        CMD_DRAW: begin
          // scale the fraction by the running sum, then walk the bins from the oldest
          target  = (longint'(r) * wsum) >> RANDOM_BITS;
          partial = 0;
          for (i = 0; i < total; i++) begin
            if (partial <= target && target < partial + weights[i]) begin
              e.found = 1'b1;
              e.pick  = CNT_W'(total - i);
              break;
            end
            partial += weights[i];
          end
        end
        default: ;
      endcase
      expected_picks.insert(expected_picks.size(), e);
    endfunction

    // Compare one accepted result against the oldest expectation
    task check_result(input logic [CNT_W-1:0] pick, input logic found,
                      input logic st);
      pick_result_t e;
      seen++;
      if (expected_picks.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending (pick %0d)", seen, pick));
        return;
      end
      e = expected_picks.pop_front();
      if (pick !== e.pick)
        report($sformatf("result %0d picked_boundary got %0d want %0d", seen, pick, e.pick));
      if (found !== e.found)
        report($sformatf("result %0d bin_found got %b want %b", seen, found, e.found));
      if (st !== e.status)
        report($sformatf("result %0d status got %b want %b", seen, st, e.status));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_stall;
  logic [CMD_W-1:0]       command;
  logic [IDX_W-1:0]       entry_index;
  logic [WEIGHT_W-1:0]    weight_value;
  logic [COUNT_W-1:0]     boundary_count;
  logic [RANDOM_BITS-1:0] random_fraction;
  logic                   result_valid;
  logic                   result_stall;
  logic [CNT_W-1:0]       picked_boundary;
  logic                   bin_found;
  logic                   status;

  selection_scoreboard sb = new();

  // Stimulus bookkeeping: which weights exist and how far adds have reached
  bit loaded [TABLE_DEPTH];
  int plan_total = 0;
  int words_sent = 0;
  bit hold_req   = 1'b0;

  decayed_boundary_selector DUT (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .command         (command),
    .entry_index     (entry_index),
    .weight_value    (weight_value),
    .boundary_count  (boundary_count),
    .random_fraction (random_fraction),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .picked_boundary (picked_boundary),
    .bin_found       (bin_found),
    .status          (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return '0;
    if (p < 18) return WEIGHT_ONE;
    if (p < 28) return WEIGHT_W'($urandom_range(65537, 131071));
    return WEIGHT_W'($urandom_range(1, 65535));
  endfunction

  // Watch both handshakes at the edge
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      sb.note_word(cmd_t'(command), entry_index, weight_value, boundary_count,
                   random_fraction);
    if (!rst && result_valid && !result_stall)
      sb.check_result(picked_boundary, bin_found, status);
  end

  // Result side: random stalls, open stretches, and one long hold on request
  initial begin : result_side
    int n;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
        repeat (n) @(posedge clk);
        n = idle_len();
        if (n > 0) begin
          result_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                           input logic [WEIGHT_W-1:0] w, input logic [COUNT_W-1:0] cnt,
                           input logic [RANDOM_BITS-1:0] r);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    command         <= c;
    entry_index     <= idx;
    weight_value    <= w;
    boundary_count  <= cnt;
    random_fraction <= r;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic load_entry(input int idx, input logic [WEIGHT_W-1:0] w);
    send_word(CMD_LOAD, IDX_W'(idx), w, COUNT_W'($urandom), RANDOM_BITS'($urandom));
    loaded[idx] = 1'b1;
  endtask

  // Fill any weight the add would read, then add
  task automatic add_bounds(input int cnt);
    int i;
    for (i = plan_total; i < plan_total + cnt && i < TABLE_DEPTH; i++)
      if (!loaded[i]) load_entry(i, rand_weight());
    send_word(CMD_ADD, IDX_W'($urandom), WEIGHT_W'($urandom), COUNT_W'(cnt),
              RANDOM_BITS'($urandom));
    plan_total = (plan_total + cnt > TABLE_DEPTH) ? TABLE_DEPTH : plan_total + cnt;
  endtask

  task automatic draw(input int r);
    send_word(CMD_DRAW, IDX_W'($urandom), WEIGHT_W'($urandom), COUNT_W'($urandom),
              RANDOM_BITS'(r));
  endtask

  task automatic idle_word();
    send_word(CMD_NONE, IDX_W'($urandom), WEIGHT_W'($urandom), COUNT_W'($urandom),
              RANDOM_BITS'($urandom));
  endtask

  // Drop valid and wait for every owed result
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int  start;
    int  p;
    bit  held;
    held            = 1'b0;
    rst             <= 1'b1;
    item_valid      <= 1'b0;
    command         <= CMD_NONE;
    entry_index     <= '0;
    weight_value    <= '0;
    boundary_count  <= '0;
    random_fraction <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: unused command, empty draws, empty add
    idle_word();
    draw(0);
    draw(65535);
    add_bounds(0);
    // Clamp above one at the top index; alternating bit patterns
    load_entry(TABLE_DEPTH - 1, '1);
    load_entry(12'hAAA, 17'h15555);
    load_entry(12'h555, 17'h0AAAA);
    // Zero-weight boundaries: sum stays zero, draw misses
    load_entry(0, '0);
    load_entry(1, '0);
    add_bounds(2);
    draw(40000);
    // Full, tiny and full weights behind two empty bins
    load_entry(2, WEIGHT_ONE);
    load_entry(3, 17'd1);
    load_entry(4, WEIGHT_ONE);
    add_bounds(3);
    draw(0);
    draw(65535);
    draw(32768);
    // Stale sum: shrink a covered weight, top of range falls past every bin
    load_entry(2, '0);
    draw(65535);
    draw(1);
    load_entry(2, 17'h1FFFF);
    draw(65535);
    drain();

    // Random: grow the boundary set, reweight, draw; long result hold midway
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      if (!held && words_sent - start >= 50) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      p = $urandom_range(0, 99);
      if (p < 35)
        draw($urandom_range(0, 65535));
      else if (p < 55) begin
        if ($urandom_range(0, 19) == 0 && plan_total < 400)
          add_bounds($urandom_range(20, 40));
        else
          add_bounds(plan_total < 400 ? $urandom_range(0, 8) : 0);
      end else if (p < 70 && plan_total > 0)
        load_entry($urandom_range(0, plan_total - 1), rand_weight());
      else if (p < 90)
        load_entry($urandom_range(0, TABLE_DEPTH - 1), rand_weight());
      else
        idle_word();
    end
    drain();

    // Closing draws at both ends of the range and an empty add
    draw(65535);
    draw($urandom_range(0, 65535));
    draw(0);
    add_bounds(0);

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
